/* rtl/windowed_hit_readout_packer_macros.svh */
// ----------------------------------------------------------------------------
// Windowed hit readout packer assertion macros
// Shared assertion forms for the readout packer.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_HIT_READOUT_PACKER_MACROS_SVH
`define WINDOWED_HIT_READOUT_PACKER_MACROS_SVH

// same-cycle implication
`define WHRP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("whrp assertion failed");

// next-cycle implication
`define WHRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("whrp assertion failed");

`endif

/* rtl/whrp_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed hit readout packer package
// Sizes, request and register codes shared by the packer and its interfaces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package whrp_pkg;

	localparam int ROWS          = 256;
	localparam int SLOTS_PER_ROW = 4;
	localparam int ROW_W         = $clog2(ROWS);
	localparam int SLOT_AW       = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
	localparam int ADDR_W        = ROW_W + SLOT_AW;
	localparam int MEM_DEPTH     = ROWS << SLOT_AW;

	localparam int ENERGY_W      = 16;
	localparam int COORD_W       = 10;
	localparam int ENTRY_W       = ENERGY_W + 3 * COORD_W;
	localparam int TIME_W        = 11;
	localparam int SLOT_FIELD_W  = 2;
	localparam int WORD_W        = 32;
	localparam int TAG_W         = 4;

	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 4;

	localparam logic [WORD_W-1:0] END_WORD = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_TRIGGER = 2'd1,
		REQ_READ    = 2'd2
	} req_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIT_TAG     = 1'b0,
		REG_INSTANCE_ID = 1'b1
	} cfg_reg_t;

endpackage

/* rtl/whrp_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface whrp_cfg_if import whrp_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink   (input valid, input reg_index, input data, output ready);
endinterface

/* rtl/whrp_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Hit writes, trigger windows and row readout requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface whrp_req_if import whrp_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic [1:0]              req_type;
	logic [ROW_W-1:0]        row_addr;
	logic [SLOT_FIELD_W-1:0] slot_index;
	logic [ENERGY_W-1:0]     hit_energy;
	logic [COORD_W-1:0]      coord_u;
	logic [COORD_W-1:0]      coord_v;
	logic [COORD_W-1:0]      coord_w;
	logic [TIME_W-1:0]       window_start;
	logic [TIME_W-1:0]       window_stop;

	modport source (
		output valid, output req_type, output row_addr, output slot_index,
		output hit_energy, output coord_u, output coord_v, output coord_w,
		output window_start, output window_stop, input ready
	);
	modport sink (
		input valid, input req_type, input row_addr, input slot_index,
		input hit_energy, input coord_u, input coord_v, input coord_w,
		input window_start, input window_stop, output ready
	);
endinterface

/* rtl/whrp_evt_if.sv */
// ----------------------------------------------------------------------------
// Event word channel
// Packed event words and the end-of-event flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface whrp_evt_if import whrp_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] event_word;
	logic              end_flag;

	modport source (output valid, output event_word, output end_flag, input ready);
	modport sink   (input valid, input event_word, input end_flag, output ready);
endinterface

/* rtl/windowed_hit_readout_packer.sv */
// ----------------------------------------------------------------------------
// Windowed hit readout packer
// Hit store with trigger window readout into packed 32-bit event words.
// ----------------------------------------------------------------------------
// Hits live in a single-port-read RAM of 256 rows by SLOTS_PER_ROW slots.
// After reset the block zeroes all MEM_DEPTH (1024) entries of that RAM and
// takes no request until done; configuration writes are taken at any time.
// A write or trigger item is handled in the idle state; a trigger with an
// empty window then loads the end word. A readout item walks the current
// row one slot at a time through the RAM's registered read: each slot is
// read, a hit then emits two words (hit word, then coordinates), and the
// end word follows when the window closes. One request is served at a time.
`timescale 1ns / 1ps
`include "windowed_hit_readout_packer_macros.svh"

module windowed_hit_readout_packer import whrp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	whrp_cfg_if.sink     cfg,
	whrp_req_if.sink     req,
	whrp_evt_if.source   evt
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD,
		ST_W1,
		ST_W2,
		ST_END
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [ROW_W-1:0]    cur_row_q;
	logic [ROW_W-1:0]    start_row_q;
	logic [ROW_W-1:0]    stop_row_q;
	logic                active_q;
	logic [SLOT_AW-1:0]  slot_q;
	logic [TAG_W-1:0]    hit_tag_q;
	logic                instance_id_q;
	logic                evt_valid_q;
	logic [WORD_W-1:0]   evt_word_q;
	logic                evt_end_q;

	logic [ENTRY_W-1:0]  mem [MEM_DEPTH];
	logic [ENTRY_W-1:0]  rd_data_q;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	logic [ENTRY_W-1:0]  mem_wd;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_ra;

	logic                req_acc;
	logic                start_scan;
	logic                load_ok;
	logic                evt_load;
	logic                last_slot;
	logic                adv_en;
	logic [ROW_W-1:0]    row_next;
	logic [ROW_W-1:0]    win_start;
	logic [ROW_W-1:0]    win_stop;
	logic [ROW_W-1:0]    row_offset;
	logic [ENERGY_W-1:0] rd_energy;
	logic [COORD_W-1:0]  rd_u;
	logic [COORD_W-1:0]  rd_v;
	logic [COORD_W-1:0]  rd_w;

	assign cfg.ready      = 1'b1;
	assign req.ready      = (state_q == ST_IDLE);
	assign evt.valid      = evt_valid_q;
	assign evt.event_word = evt_word_q;
	assign evt.end_flag   = evt_end_q;

	assign req_acc    = req.valid && req.ready;
	assign start_scan = req_acc && (req.req_type == REQ_READ) && active_q;
	assign load_ok    = !evt_valid_q || evt.ready;
	assign evt_load   = load_ok && (state_q inside {ST_W1, ST_W2, ST_END});
	assign last_slot  = (slot_q == SLOT_AW'(SLOTS_PER_ROW - 1));
	assign row_next   = cur_row_q + 1'b1;
	assign win_start  = req.window_start[TIME_W-1:TIME_W-ROW_W];
	assign win_stop   = req.window_stop[TIME_W-1:TIME_W-ROW_W];
	assign row_offset = cur_row_q - start_row_q;

	assign {rd_w, rd_v, rd_u, rd_energy} = rd_data_q;

	assign adv_en = ((state_q == ST_RD) && (rd_energy == '0)) ||
	                ((state_q == ST_W2) && load_ok);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (req_acc && (req.req_type == REQ_WRITE) &&
		             (32'(req.slot_index) < SLOTS_PER_ROW)) begin
			mem_we = 1'b1;
			mem_wa = {req.row_addr, SLOT_AW'(req.slot_index)};
			mem_wd = {req.coord_w, req.coord_v, req.coord_u, req.hit_energy};
		end
		mem_re = start_scan || (adv_en && !last_slot);
		mem_ra = start_scan ? {cur_row_q, {SLOT_AW{1'b0}}}
		                    : {cur_row_q, slot_q + 1'b1};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			cur_row_q     <= '0;
			start_row_q   <= '0;
			stop_row_q    <= '0;
			active_q      <= 1'b0;
			slot_q        <= '0;
			hit_tag_q     <= '0;
			instance_id_q <= 1'b0;
			evt_valid_q   <= 1'b0;
			evt_word_q    <= '0;
			evt_end_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					REG_HIT_TAG:     hit_tag_q <= cfg.data[TAG_W-1:0];
					REG_INSTANCE_ID: instance_id_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (evt_load) begin
				evt_valid_q <= 1'b1;
			end else if (evt.ready) begin
				evt_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						case (req.req_type)
							REQ_TRIGGER: begin
								start_row_q <= win_start;
								stop_row_q  <= win_stop;
								cur_row_q   <= win_start;
								if (win_start == win_stop) begin
									active_q <= 1'b0;
									state_q  <= ST_END;
								end else begin
									active_q <= 1'b1;
								end
							end
							REQ_READ: begin
								if (active_q) begin
									slot_q  <= '0;
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD, ST_W2: begin
					if (state_q == ST_RD && rd_energy != '0) begin
						state_q <= ST_W1;
					end
					if (state_q == ST_W2 && load_ok) begin
						evt_word_q  <= {2'b00, rd_w, rd_v, rd_u};
						evt_end_q   <= 1'b0;
					end
					if (adv_en) begin
						if (last_slot) begin
							cur_row_q <= row_next;
							if (row_next == stop_row_q) begin
								active_q <= 1'b0;
								state_q  <= ST_END;
							end else begin
								state_q <= ST_IDLE;
							end
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_W1: begin
					if (load_ok) begin
						evt_word_q  <= {1'b1, hit_tag_q, instance_id_q, 2'b00,
						                row_offset, rd_energy};
						evt_end_q   <= 1'b0;
						state_q     <= ST_W2;
					end
				end
				ST_END: begin
					if (load_ok) begin
						evt_word_q  <= END_WORD;
						evt_end_q   <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`WHRP_ASSERT_NOW(a_end_word, clk, arst_n, evt.valid && evt.end_flag, evt.event_word == END_WORD)
	`WHRP_ASSERT_NOW(a_mem_write_idle, clk, arst_n, mem_we, state_q == ST_CLEAR || state_q == ST_IDLE)
	`WHRP_ASSERT_NEXT(a_scan_starts, clk, arst_n, start_scan, state_q == ST_RD && slot_q == '0)

endmodule

/* test/tb_windowed_hit_readout_packer.sv */
// ----------------------------------------------------------------------------
// Windowed hit readout packer testbench
// Fills the hit store, opens trigger windows and reads them out row by row
// under random sender bursts and receiver stalls. A local model of the store
// and the window predicts every event word, which is checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_windowed_hit_readout_packer;
	import whrp_pkg::*;

	typedef struct {
		logic [1:0]              kind;
		logic [ROW_W-1:0]        row;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [ENERGY_W-1:0]     energy;
		logic [COORD_W-1:0]      u;
		logic [COORD_W-1:0]      v;
		logic [COORD_W-1:0]      w;
		logic [TIME_W-1:0]       t_start;
		logic [TIME_W-1:0]       t_stop;
	} hit_req_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              last;
	} evt_word_t;

	logic clk;
	logic arst_n;

	whrp_cfg_if cfg_bus();
	whrp_req_if req_bus();
	whrp_evt_if evt_bus();

	windowed_hit_readout_packer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.evt    (evt_bus)
	);

	hit_req_t  pending_reqs[$];
	evt_word_t expected_words[$];
	int        items_queued;
	int        items_accepted;
	int        fail_count;

	logic [ENERGY_W-1:0] store_energy [ROWS][SLOTS_PER_ROW];
	logic [COORD_W-1:0]  store_u      [ROWS][SLOTS_PER_ROW];
	logic [COORD_W-1:0]  store_v      [ROWS][SLOTS_PER_ROW];
	logic [COORD_W-1:0]  store_w      [ROWS][SLOTS_PER_ROW];
	logic [ROW_W-1:0]    scan_row;
	logic [ROW_W-1:0]    first_row;
	logic [ROW_W-1:0]    last_row;
	logic                window_open;
	logic [TAG_W-1:0]    tag_reg;
	logic                inst_reg;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic predict_event_words(input hit_req_t it);
		logic [ROW_W-1:0]  offset;
		logic [WORD_W-1:0] w1;
		logic [WORD_W-1:0] w2;
		case (it.kind)
			REQ_WRITE: begin
				if (it.slot < SLOTS_PER_ROW) begin
					store_energy[it.row][it.slot] = it.energy;
					store_u[it.row][it.slot] = it.u;
					store_v[it.row][it.slot] = it.v;
					store_w[it.row][it.slot] = it.w;
				end
			end
			REQ_TRIGGER: begin
				first_row = it.t_start[10:3];
				last_row = it.t_stop[10:3];
				scan_row = it.t_start[10:3];
				if (first_row == last_row) begin
					window_open = 1'b0;
					expected_words.push_back('{END_WORD, 1'b1});
				end else begin
					window_open = 1'b1;
				end
			end
			REQ_READ: begin
				if (window_open) begin
					offset = scan_row - first_row;
					for (int s = 0; s < SLOTS_PER_ROW; s++) begin
						if (store_energy[scan_row][s] != '0) begin
							w1 = {1'b1, tag_reg, inst_reg, 2'b00, offset,
								store_energy[scan_row][s]};
							w2 = {2'b00, store_w[scan_row][s], store_v[scan_row][s],
								store_u[scan_row][s]};
							expected_words.push_back('{w1, 1'b0});
							expected_words.push_back('{w2, 1'b0});
						end
					end
					scan_row = scan_row + 1'b1;
					if (scan_row == last_row) begin
						window_open = 1'b0;
						expected_words.push_back('{END_WORD, 1'b1});
					end
				end
			end
			default: ;
		endcase
	endtask

	// request driver: bursts with random gaps
	hit_req_t held_req;
	int       burst_left;
	int       gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			burst_left = 1;
			gap_left = 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				predict_event_words(held_req);
				items_accepted++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					req_bus.valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					held_req = pending_reqs.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.req_type <= held_req.kind;
					req_bus.row_addr <= held_req.row;
					req_bus.slot_index <= held_req.slot;
					req_bus.hit_energy <= held_req.energy;
					req_bus.coord_u <= held_req.u;
					req_bus.coord_v <= held_req.v;
					req_bus.coord_w <= held_req.w;
					req_bus.window_start <= held_req.t_start;
					req_bus.window_stop <= held_req.t_stop;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// event monitor with its own stall pattern
	evt_word_t want;
	int        mode;
	int        mode_left;
	int        stall_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_bus.ready <= 1'b0;
			mode = 0;
			mode_left = 0;
			stall_left = 0;
		end else begin
			if (evt_bus.valid && evt_bus.ready) begin
				if (expected_words.size() == 0) begin
					$error("event_word unexpected: expected none, actual %h",
						evt_bus.event_word);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (evt_bus.event_word !== want.word) begin
						$error("event_word mismatch: expected %h, actual %h",
							want.word, evt_bus.event_word);
						fail_count++;
					end
					if (evt_bus.end_flag !== want.last) begin
						$error("end_flag mismatch: expected %b, actual %b",
							want.last, evt_bus.end_flag);
						fail_count++;
					end
				end
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (mode)
				0: evt_bus.ready <= 1'b1;
				1: evt_bus.ready <= ($urandom_range(0, 3) != 0);
				default: begin
					if (stall_left != 0) begin
						stall_left--;
						evt_bus.ready <= 1'b0;
					end else begin
						evt_bus.ready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							stall_left = $urandom_range(1, 8);
					end
				end
			endcase
		end
	end

	function automatic hit_req_t random_req(input logic [1:0] kind);
		hit_req_t it;
		it.kind = kind;
		it.row = ROW_W'($urandom);
		it.slot = SLOT_FIELD_W'($urandom);
		it.energy = ENERGY_W'($urandom);
		it.u = COORD_W'($urandom);
		it.v = COORD_W'($urandom);
		it.w = COORD_W'($urandom);
		it.t_start = TIME_W'($urandom);
		it.t_stop = TIME_W'($urandom);
		return it;
	endfunction

	function automatic hit_req_t write_req(input logic [ROW_W-1:0] row,
		input logic [SLOT_FIELD_W-1:0] slot, input logic [ENERGY_W-1:0] energy,
		input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
		input logic [COORD_W-1:0] w);
		hit_req_t it;
		it = random_req(REQ_WRITE);
		it.row = row;
		it.slot = slot;
		it.energy = energy;
		it.u = u;
		it.v = v;
		it.w = w;
		return it;
	endfunction

	function automatic hit_req_t trigger_req(input logic [ROW_W-1:0] s,
		input logic [ROW_W-1:0] e);
		hit_req_t it;
		it = random_req(REQ_TRIGGER);
		it.t_start = {s, 3'($urandom)};
		it.t_stop = {e, 3'($urandom)};
		return it;
	endfunction

	task automatic push_req(input hit_req_t it);
		pending_reqs.push_back(it);
		items_queued++;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_HIT_TAG)
			tag_reg = val[TAG_W-1:0];
		else
			inst_reg = val[0];
	endtask

	task automatic drain_block();
		do @(posedge clk);
		while (items_accepted != items_queued || expected_words.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_directed();
		hit_req_t it;
		push_req(random_req(REQ_READ));
		push_req(random_req(2'd3));
		push_req(write_req(8'd5, 2'd0, 16'hFFFF, 10'h3FF, 10'h3FF, 10'h3FF));
		push_req(write_req(8'd5, 2'd3, 16'h0001, 10'h000, 10'h000, 10'h000));
		push_req(write_req(8'd6, 2'd1, 16'h8000, 10'h2AA, 10'h155, 10'h3FF));
		push_req(write_req(8'd7, 2'd2, 16'h0000, 10'h3FF, 10'h000, 10'h155));
		push_req(trigger_req(8'd5, 8'd8));
		repeat (3) push_req(random_req(REQ_READ));
		push_req(trigger_req(8'd100, 8'd100));
		push_req(write_req(8'd255, 2'd2, 16'hFFFF, 10'h001, 10'h001, 10'h001));
		push_req(write_req(8'd0, 2'd0, 16'h1234, 10'h0F0, 10'h30F, 10'h2AA));
		it = trigger_req(8'd255, 8'd1);
		it.t_start = '1;
		push_req(it);
		repeat (2) push_req(random_req(REQ_READ));
		push_req(trigger_req(8'd5, 8'd10));
		push_req(random_req(REQ_READ));
		push_req(trigger_req(8'd6, 8'd7));
		push_req(random_req(REQ_READ));
		push_req(trigger_req(8'd0, 8'd2));
		push_req(random_req(REQ_READ));
		push_req(write_req(8'd1, 2'd0, 16'h0007, 10'h155, 10'h2AA, 10'h000));
		push_req(random_req(REQ_READ));
		push_req(write_req(8'd5, 2'd3, 16'h0000, 10'h3FF, 10'h3FF, 10'h3FF));
	endtask

	task automatic load_random(input int n_items);
		logic [ROW_W-1:0] base;
		logic [ROW_W-1:0] srow;
		hit_req_t         it;
		int               first_cnt;
		int               pick;
		int               len;
		int               n_reads;
		first_cnt = items_queued;
		base = ROW_W'($urandom);
		while (items_queued - first_cnt < n_items) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 19) == 0)
				base = ROW_W'($urandom);
			if (pick < 40) begin
				it = random_req(REQ_WRITE);
				it.row = base + ROW_W'($urandom_range(0, 15));
				case ($urandom_range(0, 7))
					0: it.energy = '0;
					1: it.energy = '1;
					default: ;
				endcase
				push_req(it);
			end else if (pick < 80) begin
				if ($urandom_range(0, 9) == 0)
					len = 0;
				else if ($urandom_range(0, 29) == 0)
					len = $urandom_range(20, 40);
				else
					len = $urandom_range(1, 6);
				srow = base + ROW_W'($urandom_range(0, 10));
				push_req(trigger_req(srow, srow + ROW_W'(len)));
				if (len > 0 && $urandom_range(0, 4) == 0)
					n_reads = $urandom_range(0, len - 1);
				else
					n_reads = len;
				for (int k = 0; k < n_reads; k++) begin
					if ($urandom_range(0, 5) == 0) begin
						it = random_req(REQ_WRITE);
						it.row = srow + ROW_W'($urandom_range(0, len));
						push_req(it);
					end
					push_req(random_req(REQ_READ));
				end
			end else if (pick < 88) begin
				push_req(random_req(REQ_WRITE));
			end else if (pick < 94) begin
				push_req(random_req(REQ_READ));
			end else begin
				push_req(random_req(2'd3));
			end
		end
	endtask

	logic [TAG_W-1:0] phase_tag [5];
	logic             phase_inst [5];

	initial begin
		arst_n = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.reg_index = REG_HIT_TAG;
		cfg_bus.data = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_WRITE;
		req_bus.row_addr = '0;
		req_bus.slot_index = '0;
		req_bus.hit_energy = '0;
		req_bus.coord_u = '0;
		req_bus.coord_v = '0;
		req_bus.coord_w = '0;
		req_bus.window_start = '0;
		req_bus.window_stop = '0;
		evt_bus.ready = 1'b0;
		items_queued = 0;
		items_accepted = 0;
		fail_count = 0;
		for (int r = 0; r < ROWS; r++) begin
			for (int s = 0; s < SLOTS_PER_ROW; s++) begin
				store_energy[r][s] = '0;
				store_u[r][s] = '0;
				store_v[r][s] = '0;
				store_w[r][s] = '0;
			end
		end
		scan_row = '0;
		first_row = '0;
		last_row = '0;
		window_open = 1'b0;
		tag_reg = '0;
		inst_reg = 1'b0;
		phase_tag = '{4'h9, 4'hF, 4'h0, 4'hF, TAG_W'($urandom)};
		phase_inst = '{1'b1, 1'b1, 1'b0, 1'b0, 1'($urandom)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 5; p++) begin
			write_reg(REG_HIT_TAG, phase_tag[p]);
			write_reg(REG_INSTANCE_ID, {3'($urandom), phase_inst[p]});
			if (p == 0)
				load_directed();
			else
				load_random(76);
			drain_block();
		end

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* windowed_hit_readout_packer.f */
+incdir+rtl
rtl/whrp_pkg.sv
rtl/whrp_cfg_if.sv
rtl/whrp_req_if.sv
rtl/whrp_evt_if.sv
rtl/windowed_hit_readout_packer.sv
test/tb_windowed_hit_readout_packer.sv
